/* sv/mvm_pkg.sv */
// shared types, constants and defaults for the matrix-vector multiply unit
package mvm_pkg;

    // default sizing, used as the defaults of the top level parameters
    localparam int MAX_SIZE_DEF      = 1024;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // fixed field widths
    localparam int CFG_W       = 11;
    localparam int ROW_W       = 10;
    localparam int SUM_W       = 64;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;

    // size register value after reset
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // item kind carried in tuser
    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_MATRIX = 1'b1
    } t_opcode;

    // control tag that travels with a matrix element down the pipeline
    typedef struct packed {
        logic             valid;
        logic             eor;
        logic             last;
        logic [ROW_W-1:0] row;
    } t_tag;

endpackage

/* sv/mvm_ram.sv */
// generic single-write, single-read synchronous ram with registered read
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mvm_ctrl.sv */
// position tracking, vector store addressing and size register
module mvm_ctrl #(
    parameter int MAX_SIZE      = mvm_pkg::MAX_SIZE_DEF,
    parameter int ELEMENT_WIDTH = mvm_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_opcode,
    input  logic [mvm_pkg::IN_TDATA_W-1:0] i_value,
    input  logic                          i_cfg_we,
    input  logic [mvm_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_ram_we,
    output logic [$clog2(MAX_SIZE)-1:0]   o_ram_waddr,
    output logic [ELEMENT_WIDTH-1:0]      o_ram_wdata,
    output logic [$clog2(MAX_SIZE)-1:0]   o_ram_raddr,
    output mvm_pkg::t_tag                 o_tag,
    output logic [ELEMENT_WIDTH-1:0]      o_elem
);

    localparam int PW = $clog2(MAX_SIZE);
    localparam int CW = (PW + 1 > mvm_pkg::CFG_W) ? PW + 1 : mvm_pkg::CFG_W;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_SIZE);

    // zero acts as one, anything above the store depth acts as the depth
    function automatic logic [CW-1:0] clamp_size(input logic [mvm_pkg::CFG_W-1:0] raw);
        logic [CW-1:0] v;
        v = CW'(raw);
        if (v == '0) begin
            v = CW'(1);
        end else if (v > MAX_N) begin
            v = MAX_N;
        end
        return v;
    endfunction

    logic [CW-1:0]   r_n;
    logic [PW-1:0]   r_load_pos, n_load_pos;
    logic [PW-1:0]   r_col_pos,  n_col_pos;
    logic [PW-1:0]   r_row_pos,  n_row_pos;
    mvm_pkg::t_tag   r_tag, n_tag;
    logic [ELEMENT_WIDTH-1:0] r_elem;

    logic w_accept;
    logic w_is_matrix;
    logic w_load_wrap;
    logic w_col_end;
    logic w_row_last;

    assign w_accept    = i_valid && i_en;
    assign w_is_matrix = mvm_pkg::t_opcode'(i_opcode) == mvm_pkg::OP_MATRIX;
    assign w_load_wrap = (CW'(r_load_pos) + CW'(1)) >= r_n;
    assign w_col_end   = (CW'(r_col_pos) + CW'(1)) >= r_n;
    assign w_row_last  = (CW'(r_row_pos) + CW'(1)) >= r_n;

    // next positions and the tag for the accepted transaction
    always_comb begin
        n_load_pos = r_load_pos;
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        n_tag      = '0;
        if (w_accept && !w_is_matrix) begin
            n_load_pos = w_load_wrap ? '0 : r_load_pos + PW'(1);
        end
        if (w_accept && w_is_matrix) begin
            n_tag.valid = 1'b1;
            n_tag.eor   = w_col_end;
            n_tag.last  = w_col_end && w_row_last;
            n_tag.row   = mvm_pkg::ROW_W'(r_row_pos);
            if (w_col_end) begin
                n_col_pos = '0;
                n_row_pos = w_row_last ? '0 : r_row_pos + PW'(1);
            end else begin
                n_col_pos = r_col_pos + PW'(1);
            end
        end
    end

    // size register and positions; a size write restarts every position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n        <= clamp_size(mvm_pkg::SIZE_RESET);
            r_load_pos <= '0;
            r_col_pos  <= '0;
            r_row_pos  <= '0;
        end else if (i_cfg_we) begin
            r_n        <= clamp_size(i_cfg_wdata);
            r_load_pos <= '0;
            r_col_pos  <= '0;
            r_row_pos  <= '0;
        end else begin
            r_load_pos <= n_load_pos;
            r_col_pos  <= n_col_pos;
            r_row_pos  <= n_row_pos;
        end
    end

    // tag stage, aligned with the vector store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= n_tag;
        end
    end

    // element payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_elem <= i_value[ELEMENT_WIDTH-1:0];
        end
    end

    // vector store access
    assign o_ram_we    = w_accept && !w_is_matrix;
    assign o_ram_waddr = r_load_pos;
    assign o_ram_wdata = i_value[ELEMENT_WIDTH-1:0];
    assign o_ram_raddr = r_col_pos;

    assign o_tag  = r_tag;
    assign o_elem = r_elem;

endmodule

/* sv/mvm_mac.sv */
// multiply stage and saturating accumulate stage, with the result register
module mvm_mac #(
    parameter int ELEMENT_WIDTH = mvm_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_clear,
    input  mvm_pkg::t_tag                i_tag,
    input  logic [ELEMENT_WIDTH-1:0]     i_elem,
    input  logic [ELEMENT_WIDTH-1:0]     i_vec,
    output mvm_pkg::t_tag                o_mul_tag,
    output logic                         o_valid,
    output logic [mvm_pkg::SUM_W-1:0]    o_sum,
    output logic [mvm_pkg::ROW_W-1:0]    o_row,
    output logic                         o_last
);

    localparam int SW = mvm_pkg::SUM_W;

    logic signed [ELEMENT_WIDTH-1:0]   w_a;
    logic signed [ELEMENT_WIDTH-1:0]   w_b;
    logic signed [2*ELEMENT_WIDTH-1:0] w_mul;
    logic signed [SW-1:0]              r_prod;
    mvm_pkg::t_tag                     r_tag;
    logic signed [SW-1:0]              r_acc, n_acc;
    logic signed [SW:0]                w_wide;
    logic signed [SW-1:0]              w_sat;
    logic                              r_valid;
    logic [SW-1:0]                     r_sum;
    logic [mvm_pkg::ROW_W-1:0]         r_row;
    logic                              r_last;

    // exact product of element and vector entry
    assign w_a   = i_elem;
    assign w_b   = i_vec;
    assign w_mul = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= SW'(w_mul);
        end
    end

    // saturating add on one extra bit
    always_comb begin
        w_wide = {r_acc[SW-1], r_acc} + {r_prod[SW-1], r_prod};
        if (w_wide[SW] != w_wide[SW-1]) begin
            w_sat = w_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            w_sat = w_wide[SW-1:0];
        end
    end

    // accumulator restarts after each row end
    always_comb begin
        n_acc = r_acc;
        if (i_en && r_tag.valid) begin
            n_acc = r_tag.eor ? '0 : w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // result register, holds while the master side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_tag.valid && r_tag.eor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_tag.valid && r_tag.eor) begin
            r_sum  <= w_sat;
            r_row  <= r_tag.row;
            r_last <= r_tag.last;
        end
    end

    assign o_mul_tag = r_tag;
    assign o_valid   = r_valid;
    assign o_sum     = r_sum;
    assign o_row     = r_row;
    assign o_last    = r_last;

endmodule

/* sv/matrix_vector_multiply_unit.sv */
// top level of the streaming q16.16 matrix-vector multiply unit
//
//  channel   direction  signals                          accepted when
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata  tvalid && tready
//                       i_s_tuser
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata  tvalid && tready
//                       o_m_tlast
//  cfg       in         i_cfg_we/i_cfg_wdata             i_cfg_we high
//
// one transaction per cycle while o_s_tready is high; the last matrix element of a row
// passes the vector store read and multiply registers, then its row sum is accumulated
// into the result register; the vector store ram has one write and one read port, one
// access of each per cycle, which sets the rate
// reset clears positions and accumulator and sets the size to 1024; the
// vector store keeps no reset and an unwritten entry reads as whatever it holds
// a result waiting in the output register with i_m_tready low stalls the
// whole pipeline and drops o_s_tready
module matrix_vector_multiply_unit #(
    parameter int MAX_SIZE      = mvm_pkg::MAX_SIZE_DEF,
    parameter int ELEMENT_WIDTH = mvm_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [mvm_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic [0:0]                      i_s_tuser,   // [0] opcode
    // master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [mvm_pkg::OUT_TDATA_W-1:0] o_m_tdata,   // [63:0] row_sum, [73:64] row_number
    output logic                            o_m_tlast,   // last_row
    // configuration
    input  logic                            i_cfg_we,
    input  logic [mvm_pkg::CFG_W-1:0]       i_cfg_wdata  // size_in_use
);

    localparam int PW = $clog2(MAX_SIZE);
    localparam int PAD_W = mvm_pkg::OUT_TDATA_W - mvm_pkg::SUM_W - mvm_pkg::ROW_W;

    logic                          w_en;
    logic                          w_ram_we;
    logic [PW-1:0]                 w_ram_waddr;
    logic [ELEMENT_WIDTH-1:0]      w_ram_wdata;
    logic [PW-1:0]                 w_ram_raddr;
    logic [ELEMENT_WIDTH-1:0]      w_ram_rdata;
    mvm_pkg::t_tag                 w_tag_a;
    mvm_pkg::t_tag                 w_tag_b;
    logic [ELEMENT_WIDTH-1:0]      w_elem;
    logic [mvm_pkg::SUM_W-1:0]     w_sum;
    logic [mvm_pkg::ROW_W-1:0]     w_row;

    // pipeline advances whenever the result register is free or drains
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // positions and store addressing
    mvm_ctrl #(
        .MAX_SIZE      (MAX_SIZE),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_s_tvalid),
        .i_opcode    (i_s_tuser[0]),
        .i_value     (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .o_tag       (w_tag_a),
        .o_elem      (w_elem)
    );

    // vector store
    mvm_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (MAX_SIZE)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_en),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // multiply-accumulate and result register
    mvm_mac #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_clear   (i_cfg_we),
        .i_tag     (w_tag_a),
        .i_elem    (w_elem),
        .i_vec     (w_ram_rdata),
        .o_mul_tag (w_tag_b),
        .o_valid   (o_m_tvalid),
        .o_sum     (w_sum),
        .o_row     (w_row),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {{PAD_W{1'b0}}, w_row, w_sum};

    // a held result blocks new transactions
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while result register is stalled");

    // the final row flag only comes with a row end
    a_last_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag_a.valid && w_tag_a.last |-> w_tag_a.eor)
        else $error("final row flagged on an element that ends no row");

    // a new result follows a row end leaving the multiply stage
    a_result_from_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_tag_b.valid && w_tag_b.eor && w_en))
        else $error("result appeared without a row end in the pipeline");

endmodule

/* dv/mvm_row_checker.sv */
// row sum predictor and result checker for the matrix-vector multiply unit
module mvm_row_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [mvm_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic [0:0]                      i_s_tuser,   // [0] opcode
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [mvm_pkg::OUT_TDATA_W-1:0] i_m_tdata,   // [63:0] row_sum, [73:64] row_number
    input  logic                            i_m_tlast,   // last_row
    input  logic                            i_cfg_we,
    input  logic [mvm_pkg::CFG_W-1:0]       i_cfg_wdata, // size_in_use
    output int                              o_fail_count,
    output int                              o_rows_owed
);

    localparam int MAX_N = mvm_pkg::MAX_SIZE_DEF;
    localparam int EW    = mvm_pkg::ELEMENT_WIDTH_DEF;
    localparam int SW    = mvm_pkg::SUM_W;
    localparam int RW    = mvm_pkg::ROW_W;

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic [RW-1:0]        row;
        logic                 last;
    } t_row_sum;

    // shadow copy of the block state
    logic signed [31:0]   vector_mem [MAX_N];
    int unsigned          dim;
    int unsigned          load_pos;
    int unsigned          col_pos;
    int unsigned          row_pos;
    logic signed [SW-1:0] running_sum;
    t_row_sum             owed_rows[$];

    function automatic int unsigned clamp_size(input logic [mvm_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_N)
            return MAX_N;
        return v;
    endfunction

    // signed 64-bit add that sticks at the limits
    function automatic logic signed [SW-1:0] add_sat(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1])
            return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        return s[SW-1:0];
    endfunction

    // one accepted element: vector load or matrix multiply-accumulate
    task automatic take_element(input mvm_pkg::t_opcode op, input logic [31:0] raw);
        logic [31:0]        shifted;
        logic signed [31:0] elem;
        logic [SW-1:0]      prod;
        logic signed [31:0] vec;
        t_row_sum           r;
        shifted = raw << (32 - EW);
        elem    = $signed(shifted) >>> (32 - EW);
        if (op == mvm_pkg::OP_LOAD) begin
            if (load_pos >= dim)
                load_pos = 0;
            vector_mem[load_pos] = elem;
            load_pos++;
            if (load_pos >= dim)
                load_pos = 0;
        end else begin
            if (col_pos >= dim)
                col_pos = 0;
            if (row_pos >= dim)
                row_pos = 0;
            vec  = vector_mem[col_pos];
            // low 64 bits of the sign-extended product equal the signed product
            prod = {{32{elem[31]}}, elem} * {{32{vec[31]}}, vec};
            running_sum = add_sat(running_sum, $signed(prod));
            col_pos++;
            if (col_pos >= dim) begin
                col_pos = 0;
                r.sum   = running_sum;
                r.row   = row_pos[RW-1:0];
                r.last  = (row_pos + 1 >= dim);
                owed_rows.push_back(r);
                running_sum = '0;
                row_pos++;
                if (row_pos >= dim)
                    row_pos = 0;
            end
        end
    endtask

    // compare one result transaction with the oldest owed row
    task automatic check_row();
        t_row_sum exp_row;
        if (owed_rows.size() == 0) begin
            $display("%0t: unexpected result, expected none, got sum %h row %0d last %0b",
                     $time, i_m_tdata[63:0], i_m_tdata[73:64], i_m_tlast);
            o_fail_count++;
        end else begin
            exp_row = owed_rows.pop_front();
            if (i_m_tdata[63:0] !== exp_row.sum) begin
                $display("%0t: row_sum mismatch, expected %h, got %h",
                         $time, exp_row.sum, i_m_tdata[63:0]);
                o_fail_count++;
            end
            if (i_m_tdata[73:64] !== exp_row.row) begin
                $display("%0t: row_number mismatch, expected %0d, got %0d",
                         $time, exp_row.row, i_m_tdata[73:64]);
                o_fail_count++;
            end
            if (i_m_tlast !== exp_row.last) begin
                $display("%0t: last_row mismatch, expected %0b, got %0b",
                         $time, exp_row.last, i_m_tlast);
                o_fail_count++;
            end
        end
    endtask

    // watch all channels on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dim          = clamp_size(mvm_pkg::SIZE_RESET);
            load_pos     = 0;
            col_pos      = 0;
            row_pos      = 0;
            running_sum  = '0;
            o_fail_count = 0;
            owed_rows.delete();
        end else begin
            if (i_cfg_we) begin
                dim         = clamp_size(i_cfg_wdata);
                load_pos    = 0;
                col_pos     = 0;
                row_pos     = 0;
                running_sum = '0;
            end
            if (i_s_tvalid && i_s_tready)
                take_element(mvm_pkg::t_opcode'(i_s_tuser), i_s_tdata);
            if (i_m_tvalid && i_m_tready)
                check_row();
        end
        o_rows_owed = owed_rows.size();
    end

endmodule

/* dv/matrix_vector_multiply_unit_tb.sv */
// stimulus, clocking and verdict for the matrix-vector multiply unit
module matrix_vector_multiply_unit_tb;

    localparam int MAX_N        = mvm_pkg::MAX_SIZE_DEF;
    localparam int SETTLE       = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1150;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [mvm_pkg::IN_TDATA_W-1:0]  i_s_tdata;   // [31:0] value
    logic [0:0]                      i_s_tuser;   // [0] opcode
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [mvm_pkg::OUT_TDATA_W-1:0] o_m_tdata;   // [63:0] row_sum, [73:64] row_number
    logic                            o_m_tlast;   // last_row
    logic                            i_cfg_we;
    logic [mvm_pkg::CFG_W-1:0]       i_cfg_wdata; // size_in_use

    int fail_count;
    int rows_owed;
    int idle_cycles;

    // positions the stimulus tracks so no unwritten vector entry is read
    int unsigned cur_dim;
    int unsigned next_load;
    int unsigned next_col;
    bit          loaded [MAX_N];
    bit          steady;

    matrix_vector_multiply_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mvm_row_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_rows_owed  (rows_owed)
    );

    // 10 unit clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return VAL_MIN;
        if (r < 20)
            return VAL_MAX;
        if (r < 25)
            return '0;
        if (r < 55)
            return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        return $urandom;
    endfunction

    function automatic int unsigned clamp_size(input logic [mvm_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_N)
            return MAX_N;
        return v;
    endfunction

    // one input transaction, with an optional gap before it
    task automatic send_item(input mvm_pkg::t_opcode op, input logic [31:0] val);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = val;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (op == mvm_pkg::OP_LOAD) begin
            loaded[next_load] = 1'b1;
            next_load = (next_load + 1 >= cur_dim) ? 0 : next_load + 1;
        end else begin
            next_col = (next_col + 1 >= cur_dim) ? 0 : next_col + 1;
        end
    endtask

    // mostly matrix elements, loads mixed in, never reading an unwritten entry
    task automatic send_random_item();
        mvm_pkg::t_opcode op;
        op = mvm_pkg::OP_MATRIX;
        if ($urandom_range(0, 99) < 15 || !loaded[next_col])
            op = mvm_pkg::OP_LOAD;
        send_item(op, pick_value());
    endtask

    // let every owed row drain, then give the pipeline time to empty
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (rows_owed != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [mvm_pkg::CFG_W-1:0] v);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        cur_dim   = clamp_size(v);
        next_load = 0;
        next_col  = 0;
    endtask

    // random stalls on the result side
    initial begin
        int n;
        i_m_tready = 1'b0;
        forever begin
            n = $urandom_range(1, 40);
            i_m_tready = 1'b1;
            repeat (n) @(negedge i_clk);
            n = gap_len();
            if (n > 0) begin
                i_m_tready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        int sent;
        int phase_len;
        int dim_pick;
        bit paused;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = mvm_pkg::OP_LOAD;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        cur_dim     = clamp_size(mvm_pkg::SIZE_RESET);
        next_load   = 0;
        next_col    = 0;
        steady      = 1'b0;
        paused      = 1'b0;
        sent        = 0;
        foreach (loaded[k])
            loaded[k] = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size: a few loads and matrix elements, no row ends
        send_item(mvm_pkg::OP_LOAD, 32'h0001_0000);
        send_item(mvm_pkg::OP_LOAD, 32'hffff_0000);
        send_item(mvm_pkg::OP_MATRIX, 32'h0002_0000);
        send_item(mvm_pkg::OP_MATRIX, VAL_MAX);

        // size 3: positive and negative saturation, load in the middle of a row
        write_size(3);
        repeat (3) send_item(mvm_pkg::OP_LOAD, VAL_MIN);
        repeat (3) send_item(mvm_pkg::OP_MATRIX, VAL_MIN);
        repeat (3) send_item(mvm_pkg::OP_MATRIX, VAL_MAX);
        send_item(mvm_pkg::OP_MATRIX, '0);
        send_item(mvm_pkg::OP_LOAD, 32'h0001_0000);
        send_item(mvm_pkg::OP_MATRIX, 32'hffff_ffff);
        send_item(mvm_pkg::OP_MATRIX, 32'h0000_0001);

        // size 1: every matrix element is a whole row and the last one
        write_size(1);
        send_item(mvm_pkg::OP_LOAD, 32'h0001_0000);
        send_item(mvm_pkg::OP_MATRIX, VAL_MAX);
        send_item(mvm_pkg::OP_MATRIX, VAL_MIN);

        // size zero behaves as one
        write_size(0);
        send_item(mvm_pkg::OP_MATRIX, 32'h0001_8000);

        // oversize value acts as the largest size, then the largest size itself
        steady = $urandom_range(0, 1);
        write_size(11'h7ff);
        repeat (8) send_item(mvm_pkg::OP_LOAD, pick_value());
        repeat (8) send_item(mvm_pkg::OP_MATRIX, pick_value());
        write_size(MAX_N);
        repeat (4) send_item(mvm_pkg::OP_MATRIX, pick_value());

        // random phases over mostly small sizes
        while (sent < RANDOM_ITEMS) begin
            dim_pick = $urandom_range(0, 99);
            if (dim_pick < 8)
                write_size(1);
            else if (dim_pick < 85)
                write_size($urandom_range(2, 12));
            else
                write_size($urandom_range(13, 40));
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 80) begin
                repeat (cur_dim) send_item(mvm_pkg::OP_LOAD, pick_value());
                sent += cur_dim;
            end
            phase_len = $urandom_range(40, 120);
            for (int i = 0; i < phase_len; i++) begin
                // hold the sender until every owed row is out
                if (i == phase_len / 2 && (!paused || $urandom_range(0, 4) == 0)) begin
                    paused     = 1'b1;
                    i_s_tvalid = 1'b0;
                    while (rows_owed != 0)
                        @(negedge i_clk);
                end
                send_random_item();
            end
            sent += phase_len;
        end

        // drain and decide
        settle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
